[hw/rtl/b64d_pkg.sv]
// shared types, constants and the character classifier of the base64 stream decoder
package b64d_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CHAR_PAD        = 8'h3D;
    localparam logic [7:0] CHAR_MINUS      = 8'h2D;
    localparam logic [7:0] CHAR_PLUS       = 8'h2B;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_SLASH      = 8'h2F;
    localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0    = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9    = 8'h39;

    localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
    localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
    localparam logic [5:0] SEXTET_62         = 6'd62;
    localparam logic [5:0] SEXTET_63         = 6'd63;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } sextet_t;

    // one queue entry: the bytes that one character gives, plus the end flag
    typedef struct packed {
        logic [1:0]      nbytes;
        logic [2:0][7:0] bytes;
        logic            msg_end;
    } group_t;

    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t    s;
        logic [7:0] d;
        s = '{valid: 1'b1, value: 6'd0};
        d = 8'd0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            d = c - CHAR_UPPER_A;
            s.value = d[5:0];
        end
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
        begin
            d = c - CHAR_LOWER_A;
            s.value = d[5:0] + SEXTET_LOWER_BASE;
        end
        else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
        begin
            d = c - CHAR_DIGIT_0;
            s.value = d[5:0] + SEXTET_DIGIT_BASE;
        end
        else if (c == CHAR_MINUS || c == CHAR_PLUS)
        begin
            s.value = SEXTET_62;
        end
        else if (c == CHAR_UNDERSCORE || c == CHAR_SLASH)
        begin
            s.value = SEXTET_63;
        end
        else
        begin
            s.valid = 1'b0;
        end
        return s;
    endfunction

endpackage

[hw/rtl/b64d_if.sv]
// channel interfaces for the character input and the byte output
interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       message_end;

    modport source (output valid, output text_char, output message_end, input ready);
    modport sink (input valid, input text_char, input message_end, output ready);
endinterface

interface b64d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       run_last;
    logic       message_done;

    modport source (output valid, output data_byte, output byte_valid,
                    output run_last, output message_done, input ready);
    modport sink (input valid, input data_byte, input byte_valid,
                  input run_last, input message_done, output ready);
endinterface

[hw/rtl/b64d_front.sv]
// front end: accepts characters, keeps the sextet accumulator and builds byte groups
module b64d_front
    import b64d_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  logic   [7:0] in_char,
    input  logic   in_end,
    input  logic   q_full,
    output logic   in_ready,
    output logic   push,
    output group_t push_group
);

    logic [17:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        pad_reg, pad_next;
    logic        accept;
    sextet_t     sx;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign sx       = sextet_of(in_char);

    always_comb
    begin
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        pad_next   = pad_reg;
        push_group = '0;
        if (!pad_reg)
        begin
            if (in_char == CHAR_PAD)
            begin
                pad_next = 1'b1;
            end
            else if (sx.valid)
            begin
                if (cnt_reg == 2'd3)
                begin
                    push_group.nbytes = 2'd3;
                    push_group.bytes  = {{acc_reg[1:0], sx.value}, acc_reg[9:2], acc_reg[17:10]};
                    acc_next = '0;
                    cnt_next = 2'd0;
                end
                else
                begin
                    acc_next = {acc_reg[11:0], sx.value};
                    cnt_next = cnt_reg + 2'd1;
                end
            end
        end
        if (in_end)
        begin
            // flush a partial group; a full group just emitted leaves count at zero
            if (cnt_next == 2'd2)
            begin
                push_group.nbytes   = 2'd1;
                push_group.bytes[0] = acc_next[11:4];
            end
            else if (cnt_next == 2'd3)
            begin
                push_group.nbytes   = 2'd2;
                push_group.bytes[0] = acc_next[17:10];
                push_group.bytes[1] = acc_next[9:2];
            end
            push_group.msg_end = 1'b1;
            acc_next = '0;
            cnt_next = 2'd0;
            pad_next = 1'b0;
        end
    end

    assign push = accept && (push_group.nbytes != 2'd0 || in_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= 2'd0;
            pad_reg <= 1'b0;
        end
        else if (accept)
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            pad_reg <= pad_next;
        end
    end

endmodule

[hw/rtl/b64d_queue.sv]
// short group queue between front and back end
module b64d_queue
    import b64d_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  group_t push_group,
    input  logic   pop,
    output logic   full,
    output logic   empty,
    output group_t head
);

    group_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_group;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

[hw/rtl/b64d_back.sv]
// back end: walks the head group one byte per transaction
module b64d_back
    import b64d_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   empty,
    input  group_t head,
    output logic   pop,
    output logic   out_valid,
    input  logic   out_ready,
    output logic   [7:0] out_byte,
    output logic   out_byte_valid,
    output logic   out_run_last,
    output logic   out_message_done
);

    logic [1:0] idx_reg, idx_next;
    logic [1:0] total;
    logic       last;
    logic       take;

    // an end group with no bytes still gives one empty marker
    assign total     = (head.nbytes == 2'd0) ? 2'd1 : head.nbytes;
    assign last      = (idx_reg == total - 2'd1);
    assign out_valid = !empty;
    assign take      = out_valid && out_ready;
    assign pop       = take && last;

    assign out_byte_valid   = (head.nbytes != 2'd0);
    assign out_run_last     = last;
    assign out_message_done = last && head.msg_end;

    always_comb
    begin
        case (idx_reg)
            2'd0:    out_byte = head.bytes[0];
            2'd1:    out_byte = head.bytes[1];
            2'd2:    out_byte = head.bytes[2];
            default: out_byte = 8'd0;
        endcase
        if (!out_byte_valid)
        begin
            out_byte = 8'd0;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (take)
        begin
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

[hw/rtl/base64url_stream_decoder_unit.sv]
// base64 stream decoder: one text character per transaction in, one byte per transaction out
//
// text channel: one character per transaction with a message end flag; both the url-safe
// and the standard alphabet decode, other characters are skipped, '=' mutes the rest of
// the message. data channel: one decoded byte per transaction, with run_last on the last
// byte that a character caused and message_done on the last one of a message; an end
// character with nothing to flush gives one empty transaction (byte_valid low).
// a character is taken every cycle while the four-entry group queue has room; a character
// that completes a group or ends a message shows its first byte on the data channel the
// cycle after it is taken (when the queue was empty). while the receiver is ready, the
// data side moves one byte per cycle, so four characters in (three bytes out) keep pace;
// the group queue sets how long a burst of group-completing characters can run ahead.
// when the receiver stalls, bytes wait in the queue and text ready drops once it is full.
// reset clears the accumulator, the pad flag, the queue and the byte index; nothing else
// needs clearing and the block takes characters right after reset.
module base64url_stream_decoder_unit
    import b64d_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    b64d_in_if.sink    text,
    b64d_out_if.source data
);

    logic   q_push, q_pop, q_full, q_empty;
    group_t q_in, q_head;

    b64d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (text.valid),
        .in_char    (text.text_char),
        .in_end     (text.message_end),
        .q_full     (q_full),
        .in_ready   (text.ready),
        .push       (q_push),
        .push_group (q_in)
    );

    b64d_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_group (q_in),
        .pop        (q_pop),
        .full       (q_full),
        .empty      (q_empty),
        .head       (q_head)
    );

    b64d_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .empty            (q_empty),
        .head             (q_head),
        .pop              (q_pop),
        .out_valid        (data.valid),
        .out_ready        (data.ready),
        .out_byte         (data.data_byte),
        .out_byte_valid   (data.byte_valid),
        .out_run_last     (data.run_last),
        .out_message_done (data.message_done)
    );

`ifndef NO_ASSERTIONS
    // a group is never pushed into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_full))
        else $error("group pushed into full queue");

    // a group is never popped from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) !(q_pop && q_empty))
        else $error("group popped from empty queue");

    // message end always closes the run of its character
    assert property (@(posedge clk) disable iff (!rst_n)
        (data.valid && data.message_done) |-> data.run_last)
        else $error("message_done without run_last");

    // an empty marker is a message end marker only
    assert property (@(posedge clk) disable iff (!rst_n)
        (data.valid && !data.byte_valid) |-> (data.message_done && data.data_byte == 8'd0))
        else $error("empty result outside message end");

    // a message end character always leaves a group behind
    assert property (@(posedge clk) disable iff (!rst_n)
        (text.valid && text.ready && text.message_end) |-> q_push)
        else $error("message end not queued");
`endif

endmodule
